### sv/u2u_pkg.sv
// shared types and constants for the utf-8 to utf-16 stream decoder
`timescale 1ns / 1ps

package u2u_pkg;

  localparam int unsigned UnitQDepth = 4;
  localparam int unsigned UnitQAw    = $clog2(UnitQDepth);
  localparam int unsigned UnitQCntW  = UnitQAw + 1;

  localparam logic [25:0] SuppBase     = 26'h001_0000;
  localparam logic [15:0] HighHalfBase = 16'hD800;
  localparam logic [5:0]  LowHalfTag   = 6'b110111;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [15:0] utf16_unit;
    logic        last_unit;
  } out_t;

  typedef struct packed {
    logic [2:0]  trail_pending;
    logic [15:0] unit_accumulator;
    logic [20:0] pair_accumulator;
    logic        pair_mode;
  } state_t;

  // zero, one or two units produced by one byte, first unit in unit0
  typedef struct packed {
    logic [1:0] cnt;
    out_t       unit0;
    out_t       unit1;
  } bundle_t;

endpackage

### sv/utf8_to_utf16_stream_decoder.sv
// top level: input register, decoder state and output unit queue
`timescale 1ns / 1ps
// a byte taken is held in the input register, decoded from there and its units queued
// throughput: one byte per cycle while in_stall_o is low; the port moves one unit per cycle
// while out_stall_i is low, so the two units of a four-byte sequence leave one after the other
// reset: asynchronous, clears the decoder state, the input valid flag and the unit queue

module utf8_to_utf16_stream_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  u2u_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output u2u_pkg::out_t  out_data_o
);
  import u2u_pkg::*;

  logic                 in_valid_q, in_valid_d;
  in_t                  in_q;
  state_t               st_q, st_d;
  bundle_t              bundle;
  logic [UnitQCntW-1:0] count;
  logic                 accept;

  u2u_decode u_decode (
    .valid_i  (in_valid_q),
    .req_i    (in_q),
    .st_i     (st_q),
    .st_o     (st_d),
    .bundle_o (bundle)
  );

  u2u_unit_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (bundle),
    .count_o     (count),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // keep room for two more units behind whatever the held byte pushes
  assign in_stall_o = ((UnitQCntW+1)'(count) + (UnitQCntW+1)'(bundle.cnt))
                      > (UnitQCntW+1)'(UnitQDepth - 2);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_valid_d = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      st_q       <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      st_q       <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  a_pair_needs_trail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.pair_mode |-> (st_q.trail_pending != 3'd0))
    else $error("pair mode set with no trail byte pending");

  a_eot_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_q.end_of_text) |=> (st_q == '0))
    else $error("state not cleared after end of text");

  a_idle_keeps_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |=> $stable(st_q))
    else $error("decoder state moved with no byte held");

endmodule

### sv/u2u_decode.sv
// byte decoder: next state and produced units for one utf-8 byte
`timescale 1ns / 1ps

module u2u_decode (
  input  logic            valid_i,
  input  u2u_pkg::in_t    req_i,
  input  u2u_pkg::state_t st_i,
  output u2u_pkg::state_t st_o,
  output u2u_pkg::bundle_t bundle_o
);
  import u2u_pkg::*;

  logic [7:0]  b;
  logic [3:0]  ones;
  logic [7:0]  seed;
  logic [20:0] pair_new;
  logic [15:0] unit_new;
  logic [25:0] diff;
  logic [2:0]  pend_dec;
  state_t      st_d;
  bundle_t     bnd;

  assign b        = req_i.byte_in;
  assign pend_dec = st_i.trail_pending - 3'd1;
  assign pair_new = {st_i.pair_accumulator[14:0], b[5:0]};
  assign unit_new = {st_i.unit_accumulator[9:0], b[5:0]};
  assign diff     = {5'b0, pair_new} - SuppBase;
  assign seed     = b & (8'hFF >> ones);

  // leading ones of a lead byte
  always_comb begin
    unique casez (b)
      8'b110?????: ones = 4'd2;
      8'b1110????: ones = 4'd3;
      8'b11110???: ones = 4'd4;
      8'b111110??: ones = 4'd5;
      8'b1111110?: ones = 4'd6;
      8'b11111110: ones = 4'd7;
      8'b11111111: ones = 4'd8;
      default:     ones = 4'd0;
    endcase
  end

  always_comb begin
    st_d      = st_i;
    bnd.cnt   = 2'd0;
    bnd.unit0 = '0;
    bnd.unit1 = '0;
    if (!b[7]) begin
      bnd.cnt                  = 2'd1;
      bnd.unit0.utf16_unit     = {8'b0, b};
      st_d.pair_mode           = 1'b0;
      st_d.trail_pending       = 3'd0;
    end else if (!b[6]) begin
      if (st_i.trail_pending != 3'd0) begin
        st_d.trail_pending = pend_dec;
        if (st_i.pair_mode) begin
          st_d.pair_accumulator = pair_new;
          if (pend_dec == 3'd0) begin
            bnd.cnt              = 2'd2;
            bnd.unit0.utf16_unit = diff[25:10] + HighHalfBase;
            bnd.unit1.utf16_unit = {LowHalfTag, pair_new[9:0]};
            st_d.pair_mode       = 1'b0;
          end
        end else begin
          st_d.unit_accumulator = unit_new;
          if (pend_dec == 3'd0) begin
            bnd.cnt              = 2'd1;
            bnd.unit0.utf16_unit = unit_new;
          end
        end
      end else begin
        // orphan trail byte
        st_d.pair_mode = 1'b0;
      end
    end else begin
      if (st_i.trail_pending != 3'd0) begin
        // lead mid-sequence flushes the partial unit and is dropped
        bnd.cnt              = 2'd1;
        bnd.unit0.utf16_unit = st_i.unit_accumulator;
        st_d.trail_pending   = 3'd0;
        st_d.pair_mode       = 1'b0;
      end else begin
        if (ones == 4'd4) begin
          st_d.pair_accumulator = {13'b0, seed};
          st_d.pair_mode        = 1'b1;
        end
        st_d.unit_accumulator = {8'b0, seed};
        st_d.trail_pending    = 3'(ones - 4'd1);
      end
    end

    if (req_i.end_of_text) begin
      bnd.unit0.last_unit = (bnd.cnt == 2'd1);
      bnd.unit1.last_unit = (bnd.cnt == 2'd2);
      st_d                = '0;
    end

    if (!valid_i) begin
      st_d    = st_i;
      bnd.cnt = 2'd0;
    end
  end

  assign st_o     = st_d;
  assign bundle_o = bnd;

endmodule

### sv/u2u_unit_fifo.sv
// unit queue: takes up to two units per cycle, hands out one whenever out_stall_i is low and it is not empty
`timescale 1ns / 1ps

module u2u_unit_fifo (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  u2u_pkg::bundle_t                   push_i,
  output logic [u2u_pkg::UnitQCntW-1:0]      count_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output u2u_pkg::out_t                      out_data_o
);
  import u2u_pkg::*;

  out_t                 mem_q [UnitQDepth];
  logic [UnitQAw-1:0]   wr_q, wr_d, wr_nxt;
  logic [UnitQAw-1:0]   rd_q, rd_d;
  logic [UnitQCntW-1:0] count_q, count_d;
  logic                 pop;

  assign pop    = (count_q != '0) && !out_stall_i;
  assign wr_nxt = wr_q + UnitQAw'(1);

  always_comb begin
    wr_d    = wr_q + UnitQAw'(push_i.cnt);
    rd_d    = pop ? rd_q + UnitQAw'(1) : rd_q;
    count_d = count_q + UnitQCntW'(push_i.cnt) - UnitQCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.unit0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nxt] <= push_i.unit1;
    end
  end

  assign count_o     = count_q;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_q];

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> ((UnitQCntW+1)'(count_q) + (UnitQCntW+1)'(push_i.cnt)
                             <= (UnitQCntW+1)'(UnitQDepth)))
    else $error("unit queue overflow");

  a_pop_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.cnt == 2'd0) |=> (count_q == $past(count_q) - UnitQCntW'(1)))
    else $error("queue count wrong after a lone pop");

  a_two_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt == 2'd2 && !pop) |=> (wr_q == $past(wr_q) + UnitQAw'(2)))
    else $error("write pointer wrong after a pair push");

endmodule

### dv/tb_utf8_to_utf16_stream_decoder.sv
// testbench for the utf-8 to utf-16 stream decoder: directed and random byte streams, unit scoreboard
`timescale 1ns / 1ps

module tb_utf8_to_utf16_stream_decoder;
  import u2u_pkg::*;

  localparam logic [31:0] SuppOffset   = 32'h0001_0000;
  localparam logic [15:0] LowHalfStart = 16'hDC00;
  localparam int unsigned MaxShown     = 10;
  localparam int unsigned ChunkItems   = 150;
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned DrainCycles  = 12;

  // tracks decoder state and the utf-16 units still due from the block
  class unit_scoreboard;
    out_t        units_due[$];
    logic [2:0]  trails_left;
    logic [15:0] unit_acc;
    logic [20:0] point_acc;
    bit          in_pair;
    int unsigned mismatches;
    int unsigned units_seen;
    int unsigned pairs_built;
    int unsigned bytes_taken;
    int unsigned texts_ended;

    function new();
      clear_state();
      mismatches  = 0;
      units_seen  = 0;
      pairs_built = 0;
      bytes_taken = 0;
      texts_ended = 0;
    endfunction

    function void clear_state();
      trails_left = '0;
      unit_acc    = '0;
      point_acc   = '0;
      in_pair     = 1'b0;
    endfunction

    // returns 1 for a byte that has no effect (orphan trail byte)
    function bit note_request(in_t req);
      logic [7:0]  b;
      logic [7:0]  seed;
      logic [31:0] offset;
      out_t        made[2];
      int unsigned n_made;
      int unsigned ones;
      bit          ignored;
      b       = req.byte_in;
      n_made  = 0;
      ignored = 1'b0;
      bytes_taken++;
      made[0] = '0;
      made[1] = '0;
      if (!b[7]) begin
        made[0].utf16_unit = {8'h00, b};
        n_made      = 1;
        in_pair     = 1'b0;
        trails_left = '0;
      end else if (!b[6]) begin
        if (trails_left != 0) begin
          trails_left = trails_left - 3'd1;
          if (in_pair) begin
            point_acc = {point_acc[14:0], b[5:0]};
            if (trails_left == 0) begin
              // code point offset wraps at 32 bits, halves truncated to 16
              offset = {11'b0, point_acc} - SuppOffset;
              made[0].utf16_unit = offset[25:10] + HighHalfBase;
              made[1].utf16_unit = {6'b0, offset[9:0]} + LowHalfStart;
              n_made  = 2;
              in_pair = 1'b0;
              pairs_built++;
            end
          end else begin
            unit_acc = {unit_acc[9:0], b[5:0]};
            if (trails_left == 0) begin
              made[0].utf16_unit = unit_acc;
              n_made = 1;
            end
          end
        end else begin
          in_pair = 1'b0;
          ignored = 1'b1;
        end
      end else if (trails_left != 0) begin
        // lead byte cuts the sequence short: partial unit out, lead dropped
        made[0].utf16_unit = unit_acc;
        n_made      = 1;
        trails_left = '0;
        in_pair     = 1'b0;
      end else begin
        ones = 0;
        while (ones < 8 && b[7 - ones]) ones++;
        seed = (ones >= 8) ? 8'h00 : (b & ((8'h01 << (8 - ones)) - 8'h01));
        if (ones == 4) begin
          point_acc = {13'b0, seed};
          in_pair   = 1'b1;
        end
        unit_acc    = {8'h00, seed};
        trails_left = 3'(ones - 1);
      end
      if (req.end_of_text) begin
        if (n_made != 0) made[n_made - 1].last_unit = 1'b1;
        texts_ended++;
        clear_state();
      end
      for (int i = 0; i < n_made; i++) units_due.push_back(made[i]);
      return ignored;
    endfunction

    function void check_unit(out_t got);
      out_t due;
      units_seen++;
      if (units_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("error: unit %h (last %b) arrived with nothing due",
                   got.utf16_unit, got.last_unit);
      end else begin
        due = units_due.pop_front();
        if (got.utf16_unit !== due.utf16_unit || got.last_unit !== due.last_unit) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display("error: expected unit %h last %b, got unit %h last %b",
                     due.utf16_unit, due.last_unit, got.utf16_unit, got.last_unit);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  unit_scoreboard sb;
  bit             tx_idle_en;
  bit             rx_idle_en;
  int unsigned    rx_hold;
  int unsigned    items_sent;

  utf8_to_utf16_stream_decoder i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit eot);
    in_t req;
    req.byte_in     = b;
    req.end_of_text = eot;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (!sb.note_request(req)) items_sent++;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
  endtask

  // sender goes quiet so the last request is not taken again, then waits for all due units
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.units_due.size() != 0) @(posedge clk_i);
  endtask

  // one lead plus trails, mostly complete, sometimes cut short or plain noise
  task automatic send_random_group();
    int unsigned kind;
    int unsigned trails;
    int unsigned ones;
    int unsigned n_trails;
    logic [7:0]  lead;
    kind = $urandom_range(0, 99);
    if (kind >= 95) begin
      send_byte(8'($urandom), $urandom_range(0, 99) < 3);
    end else begin
      trails = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
      if (trails == 0) begin
        lead = {1'b0, 7'($urandom)};
      end else begin
        ones = trails + 1;
        lead = (8'hFF << (8 - ones)) | (8'($urandom) & (8'hFF >> (ones + 1)));
      end
      n_trails = (kind < 80 || trails == 0) ? trails : $urandom_range(0, trails - 1);
      send_byte(lead, $urandom_range(0, 99) < 3);
      for (int i = 0; i < n_trails; i++)
        send_byte({2'b10, 6'($urandom)}, $urandom_range(0, 99) < 3);
    end
  endtask

  task automatic run_chunk(input bit tx_gaps, input bit rx_gaps);
    int unsigned target;
    tx_idle_en = tx_gaps;
    rx_idle_en = rx_gaps;
    target     = items_sent + ChunkItems;
    while (items_sent < target) send_random_group();
  endtask

  // receiver side: checks accepted units and drives the stall
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_unit(out_data_o);
      if (rx_hold != 0) begin
        stall_left = rx_hold;
        rx_hold    = 0;
      end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    logic [8:0] directed[] = '{
      9'h000, 9'h07F,                      // ascii extremes
      9'h0C3, 9'h0A9,                      // two-byte unit
      9'h0E2, 9'h082, 9'h0AC,              // three-byte unit
      9'h080,                              // orphan trail byte
      9'h0E2, 9'h041,                      // ascii abandons the sequence
      9'h0C3, 9'h0D0,                      // lead mid sequence
      9'h0F3, 9'h0C0,                      // lead mid surrogate sequence, seed only
      9'h0F8, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, // long lead, bits lost above 16
      9'h0FF, 9'h180,                      // all-ones lead cut by end of text
      9'h141,                              // end of text on an ascii byte
      9'h0F0, 9'h080, 9'h080, 9'h180       // code point below 0x10000 wraps
    };
    sb         = new();
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold    = 0;
    items_sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    wait_drained();

    run_chunk(1'b0, 1'b0);
    run_chunk(1'b1, 1'b1);
    wait_drained();
    run_chunk(1'b1, 1'b0);
    // receiver holds off while requests keep coming back to back
    rx_hold = HoldCycles;
    run_chunk(1'b0, 1'b1);
    wait_drained();
    run_chunk(1'b1, 1'b1);

    in_valid_i <= 1'b0;
    wait_drained();
    rx_idle_en = 1'b0;
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.units_due.size() != 0) begin
      $display("error: %0d units never arrived", sb.units_due.size());
      sb.mismatches += sb.units_due.size();
    end
    $display("covered %0d bytes (%0d with effect), %0d units checked",
             sb.bytes_taken, items_sent, sb.units_seen);
    $display("  %0d surrogate pairs, %0d end-of-text marks, %0d mismatches",
             sb.pairs_built, sb.texts_ended, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("utf8_to_utf16_stream_decoder regression: pass");
    end else begin
      $display("utf8_to_utf16_stream_decoder regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("utf8_to_utf16_stream_decoder regression: fail");
    $finish;
  end

endmodule
